[hw/rtl/sltc_pkg.sv]
// Shared types, character codes and the reserved word table of the token classifier.
package sltc_pkg;

   // Token kinds
   localparam logic [2:0] KIND_DEFAULT  = 3'd0;
   localparam logic [2:0] KIND_KEYWORD  = 3'd1;
   localparam logic [2:0] KIND_FUNCTION = 3'd2;
   localparam logic [2:0] KIND_NUMBER   = 3'd3;
   localparam logic [2:0] KIND_STRING   = 3'd4;
   localparam logic [2:0] KIND_COMMENT  = 3'd5;

   // Character codes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   // Scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_DASH,
      MODE_DOT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_STRING_ESC,
      MODE_IDENT,
      MODE_SPACES,
      MODE_COMMENT
   } scan_mode_type;

   // Back end phases: identifier or first token, held spaces, trailing token
   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SPACES,
      PHASE_TAIL
   } back_phase_type;

   localparam int KW_COUNT = 22;

   // Words held right-justified, last character in the low byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("and"), 64'("break"), 64'("do"), 64'("else"), 64'("elseif"),
      64'("end"), 64'("false"), 64'("for"), 64'("function"), 64'("goto"),
      64'("if"), 64'("in"), 64'("local"), 64'("nil"), 64'("not"),
      64'("or"), 64'("repeat"), 64'("return"), 64'("then"), 64'("true"),
      64'("until"), 64'("while")
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd4, 4'd2,
      4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == CH_UNDER);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c);
   endfunction

   // Reserved word match over the low len bytes of the word shift register
   function automatic logic kw_match(input logic [63:0] wbuf, input logic [3:0] len,
                                     input logic ok);
      logic [63:0] mask;
      logic        hit;
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {len, 3'b000});
      hit  = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (ok && (len == KW_LEN[i]) && ((wbuf & mask) == KW_TEXT[i])) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

[hw/rtl/script_line_token_classifier.sv]
// Top level of the script line token classifier: front end, command queue, back end.
//
//   channel  direction  tdata                          tuser        tlast
//   req_     in         char_code[7:0]                 -            line_end
//   rsp_     out        token_start[11:0], length[24:12] token_kind  run_last
//
// One character is taken per cycle while the command queue has room; the front end
// classifies it in that cycle. The back end sends one token per cycle while
// rsp_tready is high, so a step that yields n tokens sends them in turn; a
// flushed identifier with its held spaces is the longest burst (up to
// SPACE_LOOKAHEAD + 2 tokens). Synchronous reset returns both ends and the queue
// to rest; the output register holds each token until rsp_tready takes it.
module script_line_token_classifier
   import sltc_pkg::*;
#(
   parameter int MAX_LINE        = 4096,
   parameter int SPACE_LOOKAHEAD = 16,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // token_start[11:0], token_length[24:12], zero pad
   output logic [2:0]  rsp_tuser,   // token_kind[2:0]
   output logic        rsp_tlast
);
   localparam int PW    = $clog2(MAX_LINE);
   localparam int LW    = PW + 1;
   localparam int SW    = $clog2(SPACE_LOOKAHEAD + 1);
   localparam int CMD_W = 2 * (PW + LW + 3) + 1 + SW;

   logic             accept, q_push, q_pop, q_empty, q_full;
   logic [CMD_W-1:0] push_data, head_data;
   logic [PW-1:0]    out_start;
   logic [LW-1:0]    out_len;
   logic [2:0]       out_kind;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   sltc_front #(
      .MAX_LINE(MAX_LINE), .SPACE_LOOKAHEAD(SPACE_LOOKAHEAD)
   ) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .char_code(req_tdata), .line_end(req_tlast),
      .cmd_push(q_push), .cmd_data(push_data)
   );

   sltc_queue #(
      .WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(push_data),
      .pop(q_pop), .head_data(head_data), .empty(q_empty), .full(q_full)
   );

   sltc_back #(
      .MAX_LINE(MAX_LINE), .SPACE_LOOKAHEAD(SPACE_LOOKAHEAD)
   ) u_back (
      .clock(clock), .reset(reset), .head_data(head_data), .empty(q_empty),
      .pop(q_pop), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_start(out_start), .out_len(out_len), .out_kind(out_kind),
      .out_last(rsp_tlast)
   );

   assign rsp_tdata = {7'b0, 13'(out_len), 12'(out_start)};
   assign rsp_tuser = out_kind;

   // Queue never reports empty and full together
   assert property (@(posedge clock) disable iff (reset) !(q_empty && q_full))
      else $error("queue empty and full at once");

   // A command leaves the queue only when one is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");

   // Every token sent covers at least one character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:12] != 13'd0))
      else $error("zero length token");

   // Output is idle right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("token valid after reset");

endmodule

[hw/rtl/sltc_queue.sv]
// Short register queue of token commands between the front and back ends.
module sltc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign head_data = slot_ff[rd_ff];

   // Pointer and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/sltc_front.sv]
// Front end: scans one character per item and issues a token command on each step that completes a token.
module sltc_front
   import sltc_pkg::*;
#(
   parameter int MAX_LINE        = 4096,
   parameter int SPACE_LOOKAHEAD = 16,
   parameter int PW              = $clog2(MAX_LINE),
   parameter int LW              = PW + 1,
   parameter int SW              = $clog2(SPACE_LOOKAHEAD + 1),
   parameter int CMD_W           = 2 * (PW + LW + 3) + 1 + SW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_code,
   input  logic             line_end,
   output logic             cmd_push,
   output logic [CMD_W-1:0] cmd_data
);
   typedef struct packed {
      logic [PW-1:0] a_start;
      logic [LW-1:0] a_len;
      logic [2:0]    a_kind;
      logic [SW-1:0] spaces;
      logic          b_valid;
      logic [PW-1:0] b_start;
      logic [LW-1:0] b_len;
      logic [2:0]    b_kind;
   } cmd_type;

   scan_mode_type mode_ff, mode_in;
   logic [PW-1:0] pos_ff, pos_in, begin_ff, begin_in;
   logic [63:0]   wbuf_ff, wbuf_in;
   logic          long_ff, long_in, dq_ff, dq_in;
   logic [LW-1:0] wlen_ff, wlen_in;
   logic [SW-1:0] pend_ff, pend_in;

   logic          pre_v, sc, sc_v, reserved, app_res;
   logic [PW-1:0] pre_start;
   logic [LW-1:0] pre_len, sc_len, len_now;
   logic [2:0]    pre_kind, sc_kind;
   logic [SW-1:0] pre_sp;
   logic [PW-1:0] tail_start;
   logic [7:0]    quote;
   cmd_type       cmd;

   assign len_now  = LW'(pos_ff) - LW'(begin_ff) + 1'b1;
   assign reserved = kw_match(wbuf_ff, wlen_ff[3:0], !long_ff && (wlen_ff <= LW'(8)));
   assign quote    = dq_ff ? CH_DQUOTE : CH_SQUOTE;

   // Scanner step
   always_comb begin
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      wbuf_in   = wbuf_ff;
      long_in   = long_ff;
      dq_in     = dq_ff;
      wlen_in   = wlen_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      pre_v     = 1'b0;
      pre_start = begin_ff;
      pre_len   = len_now;
      pre_kind  = KIND_DEFAULT;
      pre_sp    = '0;
      sc        = 1'b0;
      sc_v      = 1'b0;
      sc_len    = LW'(1);
      sc_kind   = KIND_DEFAULT;
      tail_start = pos_ff;
      app_res   = 1'b0;
      case (mode_ff)
         MODE_DASH: begin
            if (char_code == CH_DASH) begin
               mode_in = MODE_COMMENT;
               if (line_end) begin
                  pre_v    = 1'b1;
                  pre_kind = KIND_COMMENT;
               end
            end else begin
               pre_v   = 1'b1;
               pre_len = LW'(1);
               sc      = 1'b1;
            end
         end
         MODE_DOT: begin
            if (is_digit(char_code)) begin
               mode_in = MODE_NUMBER;
               if (line_end) begin
                  pre_v    = 1'b1;
                  pre_kind = KIND_NUMBER;
               end
            end else begin
               pre_v   = 1'b1;
               pre_len = LW'(1);
               sc      = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_word(char_code) || (char_code == CH_DOT)) begin
               if (line_end) begin
                  pre_v    = 1'b1;
                  pre_kind = KIND_NUMBER;
               end
            end else begin
               pre_v    = 1'b1;
               pre_len  = len_now - 1'b1;
               pre_kind = KIND_NUMBER;
               sc       = 1'b1;
            end
         end
         MODE_STRING: begin
            if ((char_code == CH_BSLASH) && !line_end) begin
               mode_in = MODE_STRING_ESC;
            end else if ((char_code == quote) || line_end) begin
               pre_v    = 1'b1;
               pre_kind = KIND_STRING;
               mode_in  = MODE_IDLE;
            end
         end
         MODE_STRING_ESC: begin
            mode_in = MODE_STRING;
            if (line_end) begin
               pre_v    = 1'b1;
               pre_kind = KIND_STRING;
            end
         end
         MODE_COMMENT: begin
            if (line_end) begin
               pre_v    = 1'b1;
               pre_kind = KIND_COMMENT;
            end
         end
         MODE_IDENT: begin
            pre_len = wlen_ff;
            if (is_word(char_code)) begin
               // append: first eight characters kept for the keyword check
               if (wlen_ff < LW'(8)) begin
                  wbuf_in = {wbuf_ff[55:0], char_code};
               end else begin
                  long_in = 1'b1;
               end
               if (wlen_ff < LW'(MAX_LINE)) begin
                  wlen_in = wlen_ff + 1'b1;
               end
               app_res = kw_match(wbuf_in, wlen_in[3:0], !long_in && (wlen_in <= LW'(8)));
               if (line_end) begin
                  pre_v    = 1'b1;
                  pre_len  = wlen_in;
                  pre_kind = app_res ? KIND_KEYWORD : KIND_DEFAULT;
               end
            end else if (reserved) begin
               pre_v    = 1'b1;
               pre_kind = KIND_KEYWORD;
               sc       = 1'b1;
            end else if (char_code == CH_LPAREN) begin
               pre_v    = 1'b1;
               pre_kind = KIND_FUNCTION;
               sc       = 1'b1;
            end else if (char_code == CH_SPACE) begin
               mode_in = MODE_SPACES;
               pend_in = SW'(1);
               if (line_end) begin
                  pre_v  = 1'b1;
                  pre_sp = SW'(1);
               end
            end else begin
               pre_v = 1'b1;
               sc    = 1'b1;
            end
         end
         MODE_SPACES: begin
            pre_len = wlen_ff;
            if (char_code == CH_SPACE) begin
               if (pend_ff < SW'(SPACE_LOOKAHEAD)) begin
                  pend_in = pend_ff + 1'b1;
                  if (line_end) begin
                     pre_v  = 1'b1;
                     pre_sp = pend_ff + 1'b1;
                  end
               end else begin
                  // space bound reached: word, held spaces and this space
                  pre_v   = 1'b1;
                  pre_sp  = pend_ff;
                  sc_v    = 1'b1;
                  pend_in = '0;
                  mode_in = MODE_IDLE;
               end
            end else begin
               pre_v    = 1'b1;
               pre_sp   = pend_ff;
               pre_kind = (char_code == CH_LPAREN) ? KIND_FUNCTION : KIND_DEFAULT;
               pend_in  = '0;
               sc       = 1'b1;
            end
         end
         default: begin
            sc = 1'b1;
         end
      endcase

      // Character with no token open
      if (sc) begin
         mode_in  = MODE_IDLE;
         begin_in = pos_ff;
         if (char_code == CH_DASH) begin
            if (line_end) sc_v = 1'b1;
            else mode_in = MODE_DASH;
         end else if ((char_code == CH_DQUOTE) || (char_code == CH_SQUOTE)) begin
            dq_in = (char_code == CH_DQUOTE);
            if (line_end) begin
               sc_v    = 1'b1;
               sc_kind = KIND_STRING;
            end else begin
               mode_in = MODE_STRING;
            end
         end else if (is_digit(char_code)) begin
            if (line_end) begin
               sc_v    = 1'b1;
               sc_kind = KIND_NUMBER;
            end else begin
               mode_in = MODE_NUMBER;
            end
         end else if (char_code == CH_DOT) begin
            if (line_end) sc_v = 1'b1;
            else mode_in = MODE_DOT;
         end else if (is_alpha(char_code)) begin
            // no reserved word is one letter long
            wlen_in = LW'(1);
            long_in = 1'b0;
            wbuf_in = {wbuf_ff[55:0], char_code};
            if (line_end) sc_v = 1'b1;
            else mode_in = MODE_IDENT;
         end else begin
            sc_v = 1'b1;
         end
      end

      // Line end returns the scanner to its rest state
      if (line_end) begin
         pos_in   = '0;
         mode_in  = MODE_IDLE;
         begin_in = '0;
         pend_in  = '0;
         wlen_in  = '0;
         long_in  = 1'b0;
         dq_in    = 1'b0;
      end else if (pos_ff != PW'(MAX_LINE - 1)) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Command assembly: first token, held spaces, trailing token
   always_comb begin
      cmd.a_start = pre_v ? pre_start : tail_start;
      cmd.a_len   = pre_v ? pre_len : sc_len;
      cmd.a_kind  = pre_v ? pre_kind : sc_kind;
      cmd.spaces  = pre_v ? pre_sp : '0;
      cmd.b_valid = pre_v && sc_v;
      cmd.b_start = tail_start;
      cmd.b_len   = sc_len;
      cmd.b_kind  = sc_kind;
   end

   assign cmd_push = accept && (pre_v || sc_v);
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         long_ff  <= 1'b0;
         dq_ff    <= 1'b0;
         wlen_ff  <= '0;
         pend_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         long_ff  <= long_in;
         dq_ff    <= dq_in;
         wlen_ff  <= wlen_in;
         pend_ff  <= pend_in;
      end
   end

   // Word shift register, contents before the first write are don't care
   always_ff @(posedge clock) begin
      if (accept) begin
         wbuf_ff <= wbuf_in;
      end
   end

endmodule

[hw/rtl/sltc_back.sv]
// Back end: expands each token command into tokens on the output register.
module sltc_back
   import sltc_pkg::*;
#(
   parameter int MAX_LINE        = 4096,
   parameter int SPACE_LOOKAHEAD = 16,
   parameter int PW              = $clog2(MAX_LINE),
   parameter int LW              = PW + 1,
   parameter int SW              = $clog2(SPACE_LOOKAHEAD + 1),
   parameter int CMD_W           = 2 * (PW + LW + 3) + 1 + SW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CMD_W-1:0] head_data,
   input  logic             empty,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PW-1:0]    out_start,
   output logic [LW-1:0]    out_len,
   output logic [2:0]       out_kind,
   output logic             out_last
);
   typedef struct packed {
      logic [PW-1:0] a_start;
      logic [LW-1:0] a_len;
      logic [2:0]    a_kind;
      logic [SW-1:0] spaces;
      logic          b_valid;
      logic [PW-1:0] b_start;
      logic [LW-1:0] b_len;
      logic [2:0]    b_kind;
   } cmd_type;

   cmd_type        cmd;
   back_phase_type phase_ff, phase_in;
   logic [SW-1:0]  cnt_ff, cnt_in;
   logic [LW:0]    spos_ff, spos_in;
   logic           advance, tok_last;
   logic [PW-1:0]  tok_start;
   logic [LW-1:0]  tok_len;
   logic [2:0]     tok_kind;
   logic           valid_ff;
   logic [PW-1:0]  start_ff;
   logic [LW-1:0]  len_ff;
   logic [2:0]     kind_ff;
   logic           last_ff;

   assign cmd     = head_data;
   assign advance = !empty && (!valid_ff || out_ready);
   assign pop     = advance && tok_last;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      spos_in  = spos_ff;
      case (phase_ff)
         PHASE_FIRST: begin
            if (cmd.spaces != '0) begin
               phase_in = PHASE_SPACES;
               cnt_in   = cmd.spaces;
               spos_in  = (LW+1)'(cmd.a_start) + (LW+1)'(cmd.a_len);
            end else if (cmd.b_valid) begin
               phase_in = PHASE_TAIL;
            end
         end
         PHASE_SPACES: begin
            cnt_in  = cnt_ff - 1'b1;
            spos_in = spos_ff + 1'b1;
            if (cnt_ff == SW'(1)) begin
               phase_in = cmd.b_valid ? PHASE_TAIL : PHASE_FIRST;
            end
         end
         PHASE_TAIL: begin
            phase_in = PHASE_FIRST;
         end
         default: begin
            phase_in = PHASE_FIRST;
         end
      endcase
      if (tok_last) begin
         phase_in = PHASE_FIRST;
      end
   end

   // Token for the current phase
   always_comb begin
      tok_start = cmd.a_start;
      tok_len   = cmd.a_len;
      tok_kind  = cmd.a_kind;
      tok_last  = 1'b0;
      case (phase_ff)
         PHASE_FIRST: begin
            tok_last = (cmd.spaces == '0) && !cmd.b_valid;
         end
         PHASE_SPACES: begin
            // space offsets stop at the last line offset
            tok_start = (spos_ff >= (LW+1)'(MAX_LINE - 1)) ? PW'(MAX_LINE - 1)
                                                           : spos_ff[PW-1:0];
            tok_len   = LW'(1);
            tok_kind  = KIND_DEFAULT;
            tok_last  = (cnt_ff == SW'(1)) && !cmd.b_valid;
         end
         PHASE_TAIL: begin
            tok_start = cmd.b_start;
            tok_len   = cmd.b_len;
            tok_kind  = cmd.b_kind;
            tok_last  = 1'b1;
         end
         default: begin
            tok_last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         cnt_ff   <= '0;
         spos_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            spos_ff  <= spos_in;
         end
         if (advance) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff <= tok_start;
         len_ff   <= tok_len;
         kind_ff  <= tok_kind;
         last_ff  <= tok_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_start = start_ff;
   assign out_len   = len_ff;
   assign out_kind  = kind_ff;
   assign out_last  = last_ff;

endmodule
